// ===== rtl/obrb_pkg.sv =====
`default_nettype none

package obrb_pkg;

    // default sizes of the storage and the error counter
    localparam int STORE_DEPTH_DEF = 256;
    localparam int ERROR_WIDTH_DEF = 16;

    // fixed field widths
    localparam int RING_SIZE_W = 9;
    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 8;
    localparam int ERR_OUT_W   = 16;
    localparam int OP_W        = 2;
    localparam int CFG_ADDR_W  = 1;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_GET   = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_RING_SIZE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_EMPTY_BYTE = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_OUT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic finish;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== rtl/overwriting_byte_ring_buffer.sv =====
// Overwriting byte ring buffer.
// Input items arrive on the s_axis group: tuser carries the operation (put, get,
// flush), tdata the byte to store. Each item gives one result item on the m_axis
// group: the byte read (or the empty byte), overrun flag, bytes held, free space
// and the error count. Configuration goes through the plain write port: index 0
// sets the ring size (and empties the buffer), index 1 the empty byte.
// Timing: an item is taken in the idle cycle, the indices update in that cycle
// and the storage read is issued; the next cycle captures the read data and the
// fill levels, and the result is offered in the cycle after. One item is in
// flight at a time, so a new item is taken only once the result is taken;
// the steps follow from the registered read port of the storage and the single
// result register. While a result waits for m_axis_tready the input stays
// stalled and the result holds its value.
// Reset empties the buffer, clears the error count, sets the ring size to 256
// and the empty byte to zero; the storage itself needs no clearing.
`default_nettype none

module overwriting_byte_ring_buffer
    import obrb_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int ERROR_WIDTH = ERROR_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,  // [7:0] data_in
    input  wire logic [1:0]             s_axis_tuser,  // [1:0] operation
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [7:0] data_out, [8] overwrote_oldest, [16:9] bytes_held,
    // [24:17] space_free, [40:25] error_total, [47:41] zero
    output logic      [47:0]            m_axis_tdata,
    output logic      [0:0]             m_axis_tuser,  // [0] was_empty
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [RING_SIZE_W-1:0] i_cfg_wdata
);

    t_dp_cmd             cmd;
    logic [BYTE_W-1:0]   data_out;
    logic                was_empty;
    logic                overwrote;
    logic [STATUS_W-1:0] held;
    logic [STATUS_W-1:0] free;
    logic [ERR_OUT_W-1:0] error_total;

    obrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    obrb_dp #(
        .STORE_DEPTH (STORE_DEPTH),
        .ERROR_WIDTH (ERROR_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_op        (s_axis_tuser),
        .i_din       (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_data_out  (data_out),
        .o_was_empty (was_empty),
        .o_overwrote (overwrote),
        .o_held      (held),
        .o_free      (free),
        .o_error     (error_total)
    );

    // result packing
    assign m_axis_tdata = {7'd0, error_total, free, held, overwrote, data_out};
    assign m_axis_tuser = was_empty;

    // one item in flight: never ready while a result is offered
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // after an item is accepted, both sides are closed while it is worked on
    a_calc_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (!s_axis_tready && !m_axis_tvalid))
        else $error("calc cycle missing after accept");

    // the result is offered in the output state that follows the calc state
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> ##2 m_axis_tvalid)
        else $error("result not offered on time");

    // an empty get never reports an overrun
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tdata[8]))
        else $error("empty and overrun flags both set");

endmodule

`default_nettype wire

// ===== rtl/obrb_ram.sv =====
`default_nettype none

module obrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/obrb_ctrl.sv =====
`default_nettype none

module obrb_ctrl
    import obrb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_dp_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/obrb_dp.sv =====
`default_nettype none

module obrb_dp
    import obrb_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int ERROR_WIDTH = ERROR_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_dp_cmd                i_cmd,
    input  wire logic [OP_W-1:0]        i_op,
    input  wire logic [BYTE_W-1:0]      i_din,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [RING_SIZE_W-1:0] i_cfg_wdata,
    output logic      [BYTE_W-1:0]      o_data_out,
    output logic                        o_was_empty,
    output logic                        o_overwrote,
    output logic      [STATUS_W-1:0]    o_held,
    output logic      [STATUS_W-1:0]    o_free,
    output logic      [ERR_OUT_W-1:0]   o_error
);

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int SZ_W  = IDX_W + 1;
    localparam int CMP_W = (SZ_W > RING_SIZE_W) ? SZ_W : RING_SIZE_W;

    // ring state and configuration
    logic [IDX_W-1:0]       r_wi;
    logic [IDX_W-1:0]       r_ri;
    logic [ERROR_WIDTH-1:0] r_err;
    logic [SZ_W-1:0]        r_size;
    logic [BYTE_W-1:0]      r_empty_byte;

    // result registers
    logic                   r_use_ram;
    logic [BYTE_W-1:0]      r_data_out;
    logic                   r_was_empty;
    logic                   r_overwrote;
    logic [SZ_W-1:0]        r_held;
    logic [SZ_W-1:0]        r_free;

    logic                   ram_we;
    logic                   ram_re;
    logic [BYTE_W-1:0]      ram_q;
    logic [IDX_W-1:0]       wi_adv;
    logic [IDX_W-1:0]       ri_adv;
    logic [SZ_W-1:0]        held_calc;

    // clamp a written ring size to the storage range
    function automatic logic [SZ_W-1:0] f_clamp(input logic [RING_SIZE_W-1:0] v);
        logic [CMP_W-1:0] e;
        e = CMP_W'(v);
        if (e < CMP_W'(2)) begin
            e = CMP_W'(2);
        end else if (e > CMP_W'(STORE_DEPTH)) begin
            e = CMP_W'(STORE_DEPTH);
        end
        return e[SZ_W-1:0];
    endfunction

    // step an index, wrapping at the ring size
    function automatic logic [IDX_W-1:0] f_advance(input logic [IDX_W-1:0] idx,
                                                   input logic [SZ_W-1:0] size);
        logic [SZ_W-1:0] n;
        n = SZ_W'(idx) + SZ_W'(1);
        return (n >= size) ? '0 : n[IDX_W-1:0];
    endfunction

    assign wi_adv = f_advance(r_wi, r_size);
    assign ri_adv = f_advance(r_ri, r_size);

    // storage write on a put, read on a get that finds data
    assign ram_we = i_cmd.load && (i_op == OP_PUT);
    assign ram_re = i_cmd.load && (i_op == OP_GET) && (r_ri != r_wi);

    obrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wi),
        .i_wdata (i_din),
        .i_re    (ram_re),
        .i_raddr (r_ri),
        .o_rdata (ram_q)
    );

    // fill level from the updated indices
    always_comb begin
        if (r_wi < r_ri) begin
            held_calc = SZ_W'(r_wi) + r_size - SZ_W'(r_ri);
        end else begin
            held_calc = SZ_W'(r_wi) - SZ_W'(r_ri);
        end
    end

    // index, error count and configuration update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi         <= '0;
            r_ri         <= '0;
            r_err        <= '0;
            r_size       <= f_clamp(RING_SIZE_W'(256));
            r_empty_byte <= '0;
            r_use_ram    <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_use_ram <= 1'b0;
                case (i_op)
                    OP_PUT: begin
                        r_wi <= wi_adv;
                        if (wi_adv == r_ri) begin
                            r_ri  <= ri_adv;
                            r_err <= r_err + 1'b1;
                        end
                    end
                    OP_GET: begin
                        if (r_ri == r_wi) begin
                            r_err <= r_err + 1'b1;
                        end else begin
                            r_ri      <= ri_adv;
                            r_use_ram <= 1'b1;
                        end
                    end
                    OP_FLUSH: begin
                        r_wi  <= '0;
                        r_ri  <= '0;
                        r_err <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_RING_SIZE: begin
                        r_size <= f_clamp(i_cfg_wdata);
                        r_wi   <= '0;
                        r_ri   <= '0;
                    end
                    CFG_EMPTY_BYTE: begin
                        r_empty_byte <= i_cfg_wdata[BYTE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // result capture: flags and the empty byte on load, stored data and levels in the cycle after
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_data_out  <= '0;
            r_was_empty <= 1'b0;
            r_overwrote <= 1'b0;
            case (i_op)
                OP_PUT: begin
                    r_overwrote <= (wi_adv == r_ri);
                end
                OP_GET: begin
                    if (r_ri == r_wi) begin
                        r_data_out  <= r_empty_byte;
                        r_was_empty <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.finish) begin
            if (r_use_ram) begin
                r_data_out <= ram_q;
            end
            r_held <= held_calc;
            r_free <= r_size - SZ_W'(1) - held_calc;
        end
    end

    assign o_data_out  = r_data_out;
    assign o_was_empty = r_was_empty;
    assign o_overwrote = r_overwrote;
    assign o_held      = STATUS_W'(r_held);
    assign o_free      = STATUS_W'(r_free);
    assign o_error     = ERR_OUT_W'(r_err);

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
    import obrb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 200;
    localparam int SEG_ITEMS      = 260;
    localparam int FILL_PUTS      = 258;
    localparam int EMPTY_GETS     = 8;

    // code that the block leaves without effect
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // one status item as the block reports it
    typedef struct packed {
        logic [7:0]  data_out;
        logic        was_empty;
        logic        overwrote;
        logic [7:0]  held;
        logic [7:0]  free;
        logic [15:0] errors;
    } t_ring_status;

    // tracks the ring contents and queues the status each item should produce
    class t_byte_ring_tracker;
        logic [7:0]   store [STORE_DEPTH_DEF];
        int unsigned  wr_idx;
        int unsigned  rd_idx;
        logic [15:0]  err_cnt;
        logic [8:0]   size_reg;
        logic [7:0]   empty_reg;
        t_ring_status status_q [$];
        int unsigned  fail_count;
        int unsigned  n_checked;
        int unsigned  n_put, n_get, n_empty, n_over, n_flush, n_unused, n_wraps;

        function new();
            foreach (store[i]) store[i] = 8'h00;
            wr_idx     = 0;
            rd_idx     = 0;
            err_cnt    = '0;
            size_reg   = 9'd256;
            empty_reg  = 8'h00;
            fail_count = 0;
            n_checked  = 0;
            n_put      = 0;
            n_get      = 0;
            n_empty    = 0;
            n_over     = 0;
            n_flush    = 0;
            n_unused   = 0;
            n_wraps    = 0;
        endfunction

        // ring size in force, clamped to the storage
        function int unsigned slots();
            int unsigned s;
            s = size_reg;
            if (s < 2) s = 2;
            if (s > STORE_DEPTH_DEF) s = STORE_DEPTH_DEF;
            return s;
        endfunction

        function int unsigned next_idx(int unsigned idx);
            return (idx + 1 >= slots()) ? 0 : idx + 1;
        endfunction

        function void bump_errors();
            err_cnt = err_cnt + 16'd1;
            if (err_cnt == 16'd0) n_wraps++;
        endfunction

        // a ring size write empties the buffer but keeps the error count
        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [RING_SIZE_W-1:0] val);
            case (idx)
                CFG_RING_SIZE: begin
                    size_reg = val;
                    wr_idx   = 0;
                    rd_idx   = 0;
                end
                CFG_EMPTY_BYTE: begin
                    empty_reg = val[7:0];
                end
                default: ;
            endcase
        endfunction

        function void take_item(logic [OP_W-1:0] op, logic [7:0] din);
            t_ring_status st;
            int unsigned  sz;
            int unsigned  held;
            sz           = slots();
            st.data_out  = 8'h00;
            st.was_empty = 1'b0;
            st.overwrote = 1'b0;
            case (op)
                OP_PUT: begin
                    n_put++;
                    store[wr_idx] = din;
                    wr_idx = next_idx(wr_idx);
                    // full: the oldest byte goes
                    if (wr_idx == rd_idx) begin
                        rd_idx = next_idx(rd_idx);
                        bump_errors();
                        st.overwrote = 1'b1;
                        n_over++;
                    end
                end
                OP_GET: begin
                    n_get++;
                    if (rd_idx == wr_idx) begin
                        bump_errors();
                        st.data_out  = empty_reg;
                        st.was_empty = 1'b1;
                        n_empty++;
                    end else begin
                        st.data_out = store[rd_idx];
                        rd_idx = next_idx(rd_idx);
                    end
                end
                OP_FLUSH: begin
                    n_flush++;
                    wr_idx  = 0;
                    rd_idx  = 0;
                    err_cnt = '0;
                end
                default: begin
                    n_unused++;
                end
            endcase
            held      = (wr_idx < rd_idx) ? wr_idx + sz - rd_idx : wr_idx - rd_idx;
            st.held   = 8'(held);
            st.free   = 8'(sz - 1 - held);
            st.errors = err_cnt;
            status_q.push_back(st);
        endfunction

        function void flag(string msg);
            fail_count++;
            if (fail_count <= 10) $display("%s", msg);
        endfunction

        function void check_status(logic [47:0] tdata, logic [0:0] tuser);
            t_ring_status want;
            t_ring_status got;
            got.data_out  = tdata[7:0];
            got.overwrote = tdata[8];
            got.held      = tdata[16:9];
            got.free      = tdata[24:17];
            got.errors    = tdata[40:25];
            got.was_empty = tuser[0];
            if (status_q.size() == 0) begin
                flag($sformatf("result item with nothing pending: tdata %h tuser %b",
                               tdata, tuser));
                return;
            end
            want = status_q.pop_front();
            n_checked++;
            if (want !== got || tdata[47:41] !== 7'd0) begin
                flag($sformatf({"item %0d: expected data %h empty %b over %b held %0d ",
                                "free %0d errors %0d"}, n_checked, want.data_out,
                               want.was_empty, want.overwrote, want.held, want.free,
                               want.errors));
                if (fail_count <= 10)
                    $display("    got data %h empty %b over %b held %0d free %0d errors %0d pad %h",
                             got.data_out, got.was_empty, got.overwrote, got.held, got.free,
                             got.errors, tdata[47:41]);
            end
        endfunction

        function int unsigned pending();
            return status_q.size();
        endfunction

        function void close_out();
            if (status_q.size() != 0)
                flag($sformatf("%0d expected result items never arrived", status_q.size()));
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // [7:0] data_in
    logic [1:0]             s_axis_tuser;   // [1:0] operation
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [7:0] data_out, [8] overwrote_oldest, [16:9] bytes_held,
    // [24:17] space_free, [40:25] error_total, [47:41] zero
    logic [47:0]            m_axis_tdata;
    logic [0:0]             m_axis_tuser;   // [0] was_empty
    logic                   i_cfg_we;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [RING_SIZE_W-1:0] i_cfg_wdata;

    t_byte_ring_tracker ring;
    int                 send_idle_pct = 31;
    int                 recv_idle_pct = 54;
    bit                 hold_req      = 1'b0;

    overwriting_byte_ring_buffer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // offer one item, with random gaps before it, and wait until it is taken
    task automatic send_item(input logic [OP_W-1:0] op, input logic [7:0] din);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= din;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop offering and let every pending result come out
    task automatic pause_sender();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (ring.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [RING_SIZE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        ring.write_reg(addr, val);
    endtask

    // receiver: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // handshake monitor
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            ring.take_item(s_axis_tuser, s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            ring.check_status(m_axis_tdata, m_axis_tuser);
    end

    // watchdog on cycles with no traffic
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // main sequence
    initial begin
        int               seg;
        int               k;
        int               put_pct;
        int               r;
        logic [8:0]       size;
        logic [7:0]       eb;
        logic [OP_W-1:0]  op;

        ring          = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = OP_PUT;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_RING_SIZE;
        i_cfg_wdata   = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty get after reset, byte extremes, unused code
        send_item(OP_GET, 8'h3C);
        send_item(OP_PUT, 8'h00);
        send_item(OP_PUT, 8'hFF);
        send_item(OP_GET, 8'h00);
        send_item(OP_UNUSED, 8'hA5);
        send_item(OP_PUT, 8'h5A);
        // size write drops held bytes, keeps error count
        pause_sender();
        write_cfg(CFG_RING_SIZE, 9'd2);
        write_cfg(CFG_EMPTY_BYTE, 9'h0FF);
        send_item(OP_GET, 8'h11);
        // smallest ring: second put overwrites
        send_item(OP_PUT, 8'h12);
        send_item(OP_PUT, 8'h34);
        send_item(OP_GET, 8'h00);
        send_item(OP_GET, 8'h00);
        send_item(OP_FLUSH, 8'h00);
        // size below range acts as two
        pause_sender();
        write_cfg(CFG_RING_SIZE, 9'd0);
        send_item(OP_PUT, 8'h77);
        send_item(OP_PUT, 8'h88);
        send_item(OP_GET, 8'h00);
        // size above range acts as full storage
        pause_sender();
        write_cfg(CFG_RING_SIZE, 9'h1FF);
        write_cfg(CFG_EMPTY_BYTE, 9'h000);
        send_item(OP_PUT, 8'h01);
        send_item(OP_GET, 8'hFE);
        send_item(OP_GET, 8'h00);
        send_item(OP_UNUSED, 8'hFF);
        send_item(OP_FLUSH, 8'hFF);

        // random segments, each with its own ring setting; the stall mix changes every two segments
        put_pct = 50;
        for (seg = 0; seg < 6; seg++) begin
            case (seg)
                0: begin size = 9'd5;   eb = 8'hA5; end
                1: begin size = 9'd2;   eb = 8'hFF; end
                2: begin size = 9'h1FF; eb = 8'h00; end
                3: begin size = 9'd17;  eb = 8'($urandom); end
                4: begin size = 9'($urandom_range(3, 40)); eb = 8'($urandom); end
                default: begin size = 9'd256; eb = 8'h80; end
            endcase
            if (seg < 2) begin
                send_idle_pct = 31;
                recv_idle_pct = 54;
            end else if (seg < 4) begin
                send_idle_pct = 54;
                recv_idle_pct = 31;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pause_sender();
            write_cfg(CFG_RING_SIZE, size);
            write_cfg(CFG_EMPTY_BYTE, {1'b0, eb});
            // full storage: fill past capacity first
            if (seg == 2)
                for (k = 0; k < FILL_PUTS; k++) send_item(OP_PUT, 8'($urandom));
            for (k = 0; k < SEG_ITEMS; k++) begin
                if (k == 150 && (seg == 1 || seg == 5)) hold_req = 1'b1;
                if (k == 150 && seg == 3) pause_sender();
                if (k % 20 == 0) put_pct = $urandom_range(15, 85);
                r = $urandom_range(99);
                if (r < 4)
                    op = OP_FLUSH;
                else if (r < 7)
                    op = OP_UNUSED;
                else if (r - 7 < put_pct * 93 / 100)
                    op = OP_PUT;
                else
                    op = OP_GET;
                send_item(op, 8'($urandom));
            end
        end

        // short run of empty gets on a flushed ring
        pause_sender();
        write_cfg(CFG_RING_SIZE, 9'd3);
        send_item(OP_FLUSH, 8'($urandom));
        for (k = 0; k < EMPTY_GETS; k++) send_item(OP_GET, 8'($urandom));

        pause_sender();
        repeat (8) @(posedge i_clk);
        ring.close_out();

        $display("covered %0d puts, %0d gets (%0d on an empty ring), %0d overwrites,",
                 ring.n_put, ring.n_get, ring.n_empty, ring.n_over);
        $display("%0d flushes, %0d unused codes, %0d error counter wraps, %0d failures",
                 ring.n_flush, ring.n_unused, ring.n_wraps, ring.fail_count);
        if (ring.fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/obrb_pkg.sv
rtl/obrb_ram.sv
rtl/obrb_ctrl.sv
rtl/obrb_dp.sv
rtl/overwriting_byte_ring_buffer.sv
tb/tb.sv
